// ----- hdl/alle_pkg.sv -----
package alle_pkg;

    // Store sizing
    localparam int MAX_NODES  = 1024;
    localparam int VALUE_BITS = 32;
    localparam int ADDR_W     = $clog2(MAX_NODES);
    localparam int LINK_W     = ADDR_W + 1;

    // Fixed field widths
    localparam int MODE_W    = 3;
    localparam int SLOT_W    = 10;
    localparam int ELEMENT_W = 32;
    localparam int STATUS_W  = 3;
    localparam int CMP_W     = (SLOT_W > LINK_W) ? SLOT_W : LINK_W;

    // Null link marker, equal to the node count of a full store
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_NODES);

    typedef enum logic [MODE_W-1:0] {
        MODE_INS_HEAD   = 3'd0,
        MODE_INS_AFTER  = 3'd1,
        MODE_DEL_AFTER  = 3'd2,
        MODE_DEL_HEAD   = 3'd3,
        MODE_WALK_START = 3'd4,
        MODE_WALK_NEXT  = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_UNALLOC = 3'd2,
        ST_NO_SUCC = 3'd3,
        ST_EMPTY   = 3'd4
    } status_t;

    typedef struct packed {
        logic [MODE_W-1:0]           mode;
        logic [SLOT_W-1:0]           slot;
        logic signed [ELEMENT_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic signed [ELEMENT_W-1:0] element;
        logic                        element_valid;
        logic                        walk_last;
        logic [SLOT_W-1:0]           new_slot;
        logic [STATUS_W-1:0]         status;
    } out_t;

    // Sign-extend or truncate an input value to the stored width
    function automatic logic [VALUE_BITS-1:0] to_store(logic signed [ELEMENT_W-1:0] v);
        return VALUE_BITS'(v);
    endfunction

    // Sign-extend or truncate a stored value to the element width
    function automatic logic [ELEMENT_W-1:0] to_element(logic [VALUE_BITS-1:0] v);
        return ELEMENT_W'(signed'(v));
    endfunction

endpackage

// ----- hdl/array_linked_list_engine.sv -----
// Channel  | Ports                     | Payload
// request  | s_valid, s_ready, s_data  | in_t  : mode, slot, value
// result   | m_valid, m_ready, m_data  | out_t : element, element_valid, walk_last,
//          |                           |         new_slot, status
//
// Every request gives exactly one result. After acceptance the sequencer passes one state
// per dependent read of the link memory (S_LINK1, S_LINK2, S_ELEM), plus S_FIX for the second
// link write of insert-after, and loads the result register from S_EMIT.
// s_ready rises at that same edge, so a new request is taken only once the last is handed over;
// a finished result may wait in the output register while the next request is taken in.
// A stalled result holds the sequencer until the output register frees up.
// aresetn (synchronous, active low) empties the list; the memories keep no reset.
module array_linked_list_engine
    import alle_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LINK1,
        S_LINK2,
        S_FIX,
        S_ELEM,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;

    logic [MODE_W-1:0]           mode_reg, mode_next;
    logic [SLOT_W-1:0]           slot_reg, slot_next;
    logic signed [ELEMENT_W-1:0] value_reg, value_next;
    logic [LINK_W-1:0]           head_reg, head_next;
    logic [LINK_W-1:0]           used_reg, used_next;
    logic [LINK_W-1:0]           cursor_reg, cursor_next;
    out_t                        res_reg, res_next;
    out_t                        m_data_reg, m_data_next;
    logic                        m_valid_reg, m_valid_next;

    // Memory ports
    logic                  val_we, val_re, link_we, link_re;
    logic [ADDR_W-1:0]     val_wa, val_ra, link_wa, link_ra;
    logic [VALUE_BITS-1:0] val_wd, val_rd;
    logic [LINK_W-1:0]     link_wd, link_rd;

    logic full, in_slot_ok;

    alle_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_NODES)) u_values (
        .aclk    (aclk),
        .wr_en   (val_we),
        .wr_addr (val_wa),
        .wr_data (val_wd),
        .rd_en   (val_re),
        .rd_addr (val_ra),
        .rd_data (val_rd)
    );

    alle_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_links (
        .aclk    (aclk),
        .wr_en   (link_we),
        .wr_addr (link_wa),
        .wr_data (link_wd),
        .rd_en   (link_re),
        .rd_addr (link_ra),
        .rd_data (link_rd)
    );

    assign full       = (used_reg == NULL_LINK);
    assign in_slot_ok = CMP_W'(s_data.slot) < CMP_W'(used_reg);

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Sequencer: one step per dependent memory access, then a hand-over step
    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        slot_next    = slot_reg;
        value_next   = value_reg;
        head_next    = head_reg;
        used_next    = used_reg;
        cursor_next  = cursor_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        val_we  = 1'b0;
        val_re  = 1'b0;
        link_we = 1'b0;
        link_re = 1'b0;
        val_wa  = '0;
        val_ra  = '0;
        link_wa = '0;
        link_ra = '0;
        val_wd  = '0;
        link_wd = '0;

        // Drop a result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    mode_next  = s_data.mode;
                    slot_next  = s_data.slot;
                    value_next = s_data.value;
                    res_next   = '0;
                    state_next = S_EMIT;
                    unique case (s_data.mode)
                        MODE_INS_HEAD: begin
                            if (full) begin
                                res_next.status = ST_FULL;
                            end else begin
                                val_we  = 1'b1;
                                val_wa  = used_reg[ADDR_W-1:0];
                                val_wd  = to_store(s_data.value);
                                link_we = 1'b1;
                                link_wa = used_reg[ADDR_W-1:0];
                                link_wd = head_reg;
                                head_next = used_reg;
                                used_next = used_reg + 1'b1;
                                res_next.new_slot = SLOT_W'(used_reg);
                            end
                        end
                        MODE_INS_AFTER: begin
                            if (!in_slot_ok) begin
                                res_next.status = ST_UNALLOC;
                            end else if (full) begin
                                res_next.status = ST_FULL;
                            end else begin
                                link_re    = 1'b1;
                                link_ra    = ADDR_W'(s_data.slot);
                                state_next = S_LINK1;
                            end
                        end
                        MODE_DEL_AFTER: begin
                            if (!in_slot_ok) begin
                                res_next.status = ST_UNALLOC;
                            end else begin
                                link_re    = 1'b1;
                                link_ra    = ADDR_W'(s_data.slot);
                                state_next = S_LINK1;
                            end
                        end
                        MODE_DEL_HEAD: begin
                            if (head_reg >= used_reg) begin
                                res_next.status = ST_EMPTY;
                            end else begin
                                link_re    = 1'b1;
                                link_ra    = head_reg[ADDR_W-1:0];
                                state_next = S_LINK1;
                            end
                        end
                        MODE_WALK_START: begin
                            if (head_reg >= used_reg) begin
                                cursor_next     = NULL_LINK;
                                res_next.status = ST_EMPTY;
                            end else begin
                                cursor_next = head_reg;
                                val_re      = 1'b1;
                                val_ra      = head_reg[ADDR_W-1:0];
                                link_re     = 1'b1;
                                link_ra     = head_reg[ADDR_W-1:0];
                                state_next  = S_ELEM;
                            end
                        end
                        MODE_WALK_NEXT: begin
                            if (cursor_reg >= used_reg) begin
                                cursor_next     = NULL_LINK;
                                res_next.status = ST_EMPTY;
                            end else begin
                                link_re    = 1'b1;
                                link_ra    = cursor_reg[ADDR_W-1:0];
                                state_next = S_LINK1;
                            end
                        end
                        default: begin
                            // Unused modes return all zeros
                        end
                    endcase
                end
            end

            // First link read has landed
            S_LINK1: begin
                state_next = S_EMIT;
                unique case (mode_reg)
                    MODE_INS_AFTER: begin
                        val_we  = 1'b1;
                        val_wa  = used_reg[ADDR_W-1:0];
                        val_wd  = to_store(value_reg);
                        link_we = 1'b1;
                        link_wa = used_reg[ADDR_W-1:0];
                        link_wd = link_rd;
                        state_next = S_FIX;
                    end
                    MODE_DEL_AFTER: begin
                        if (link_rd >= used_reg) begin
                            res_next.status = ST_NO_SUCC;
                        end else begin
                            link_re    = 1'b1;
                            link_ra    = link_rd[ADDR_W-1:0];
                            state_next = S_LINK2;
                        end
                    end
                    MODE_DEL_HEAD: begin
                        head_next = link_rd;
                    end
                    MODE_WALK_NEXT: begin
                        if (link_rd >= used_reg) begin
                            cursor_next     = NULL_LINK;
                            res_next.status = ST_EMPTY;
                        end else begin
                            cursor_next = link_rd;
                            val_re      = 1'b1;
                            val_ra      = link_rd[ADDR_W-1:0];
                            link_re     = 1'b1;
                            link_ra     = link_rd[ADDR_W-1:0];
                            state_next  = S_ELEM;
                        end
                    end
                    default: begin
                        // No other mode reaches this step
                    end
                endcase
            end

            // Bypass the deleted successor
            S_LINK2: begin
                link_we    = 1'b1;
                link_wa    = ADDR_W'(slot_reg);
                link_wd    = link_rd;
                state_next = S_EMIT;
            end

            // Point the anchor slot at the new node and allocate it
            S_FIX: begin
                link_we   = 1'b1;
                link_wa   = ADDR_W'(slot_reg);
                link_wd   = used_reg;
                used_next = used_reg + 1'b1;
                res_next.new_slot = SLOT_W'(used_reg);
                state_next = S_EMIT;
            end

            // Value and link of the cursor node have landed
            S_ELEM: begin
                res_next.element       = to_element(val_rd);
                res_next.element_valid = 1'b1;
                res_next.walk_last     = (link_rd == NULL_LINK);
                state_next = S_EMIT;
            end

            // Hand the result over once the output register is free
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        slot_reg   <= slot_next;
        value_reg  <= value_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= NULL_LINK;
            used_reg    <= '0;
            cursor_reg  <= NULL_LINK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            used_reg    <= used_next;
            cursor_reg  <= cursor_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Allocation writes both memories together
    a_alloc_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        val_we |-> link_we)
        else $error("value written without its link");

    // The allocator only counts up by one
    a_bump: assert property (@(posedge aclk) disable iff (!aresetn)
        (used_reg != $past(used_reg)) |-> (used_reg == $past(used_reg) + 1'b1))
        else $error("allocator moved by more than one");

    // Head and cursor hold a live slot or the null marker
    a_links_live: assert property (@(posedge aclk) disable iff (!aresetn)
        ((head_reg == NULL_LINK) || (head_reg < used_reg)) &&
        ((cursor_reg == NULL_LINK) || (cursor_reg < used_reg)))
        else $error("head or cursor out of range");

    // A walk element is only reported with an ok status
    a_elem_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.element_valid) |-> (m_data.status == ST_OK))
        else $error("element reported with error status");

endmodule

// ----- hdl/alle_ram.sv -----
module alle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
